>>> design/slt_pkg.sv
package slt_pkg;

  // Default limits
  localparam int SLT_MAX_LINE_LEN  = 1024;
  localparam int SLT_MAX_TOKENS    = 64;
  localparam int SLT_MAX_TOKEN_LEN = 64;

  // Results one input byte can cause at most
  localparam int SLT_MAX_RESULTS = 4;
  localparam int SLT_CNT_W       = $clog2(SLT_MAX_RESULTS + 1);
  localparam int SLT_IDX_W       = $clog2(SLT_MAX_RESULTS);

  // Event codes
  localparam logic [1:0] EV_WORD_CHAR = 2'd0;
  localparam logic [1:0] EV_TOKEN     = 2'd1;
  localparam logic [1:0] EV_LINE      = 2'd2;

  // Token kinds
  localparam logic [2:0] KIND_WORD   = 3'd0;
  localparam logic [2:0] KIND_AND    = 3'd1;
  localparam logic [2:0] KIND_OR     = 3'd2;
  localparam logic [2:0] KIND_PIPE   = 3'd3;
  localparam logic [2:0] KIND_IN     = 3'd4;
  localparam logic [2:0] KIND_OUT    = 3'd5;
  localparam logic [2:0] KIND_APPEND = 3'd6;

  // Quoting
  localparam logic [1:0] Q_NONE   = 2'd0;
  localparam logic [1:0] Q_SINGLE = 2'd1;
  localparam logic [1:0] Q_DOUBLE = 2'd2;

  // Line status
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_TOO_LONG = 3'd2;
  localparam logic [2:0] ST_TOO_MANY = 3'd3;
  localparam logic [2:0] ST_UNSUP    = 3'd4;
  localparam logic [2:0] ST_SYNTAX   = 3'd5;

  // Characters
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_PIPE   = 8'h7C;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  typedef struct packed {
    logic       has_char;
    logic [7:0] ch;
    logic       end_of_line;
  } slt_in_t;

  typedef struct packed {
    logic [1:0] event_res;
    logic [2:0] token_kind;
    logic [1:0] quote;
    logic [7:0] word_char;
    logic [6:0] token_index;
    logic [2:0] status;
    logic       last;
  } slt_out_t;

  // All results caused by one input byte, in order from slot 0
  typedef struct packed {
    slt_out_t [SLT_MAX_RESULTS-1:0] res;
    logic [SLT_CNT_W-1:0]           cnt;
  } slt_bundle_t;

endpackage

>>> design/slt_lexer.sv
module slt_lexer import slt_pkg::*; #(
  parameter int MAX_LINE_LEN  = SLT_MAX_LINE_LEN,
  parameter int MAX_TOKENS    = SLT_MAX_TOKENS,
  parameter int MAX_TOKEN_LEN = SLT_MAX_TOKEN_LEN
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_fire,
  input  slt_in_t     in_data,
  output slt_bundle_t bundle
);

  localparam int LL_W = $clog2(MAX_LINE_LEN + 2);
  localparam int TC_W = $clog2(MAX_TOKENS + 1);
  localparam int WL_W = $clog2(MAX_TOKEN_LEN + 1);

  typedef enum logic [2:0] {
    M_BETWEEN, M_WORD, M_SQ, M_DQ, M_CLOSED, M_COMMENT, M_AMP
  } mode_t;

  typedef enum logic [1:0] {
    OP_NONE, OP_PIPE, OP_LT, OP_GT
  } pop_t;

  typedef struct packed {
    mode_t           mode;
    pop_t            pop;
    logic [7:0]      prev;
    logic [LL_W-1:0] llen;
    logic [TC_W-1:0] tc;
    logic [WL_W-1:0] wlen;
    logic [1:0]      cq;
    logic [2:0]      fe;
    logic            nul;
  } st_t;

  // Lexer state plus the results gathered so far for this byte
  typedef struct packed {
    st_t                            s;
    slt_out_t [SLT_MAX_RESULTS-1:0] r;
    logic [SLT_CNT_W-1:0]           n;
  } work_t;

  localparam st_t RESET_ST = '{
    mode: M_BETWEEN, pop: OP_NONE, prev: '0, llen: '0, tc: '0, wlen: '0,
    cq: Q_NONE, fe: ST_OK, nul: 1'b0
  };

  st_t   st_r;
  work_t w_nxt;

  function automatic logic is_space(logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic is_op(logic [7:0] c);
    return (c == CH_PIPE) || (c == CH_AMP) || (c == CH_LT) || (c == CH_GT);
  endfunction

  function automatic logic is_bad_single(logic [7:0] c);
    return (c == CH_SEMI) || (c == CH_LPAREN) || (c == CH_RPAREN) ||
           (c == CH_LBRACE) || (c == CH_RBRACE);
  endfunction

  function automatic work_t emit(work_t w, logic [1:0] ev, logic [2:0] kind,
                                 logic [1:0] q, logic [7:0] c, logic [6:0] idx,
                                 logic [2:0] stat);
    slt_out_t o;
    o = '{event_res: ev, token_kind: kind, quote: q, word_char: c,
          token_index: idx, status: stat, last: 1'b0};
    if (w.n < SLT_CNT_W'(SLT_MAX_RESULTS)) begin
      w.r[w.n[SLT_IDX_W-1:0]] = o;
      w.n = w.n + 1'b1;
    end
    return w;
  endfunction

  // Keep only the first error of the line
  function automatic work_t fail(work_t w, logic [2:0] stat);
    if (w.s.fe == ST_OK) w.s.fe = stat;
    return w;
  endfunction

  function automatic work_t push(work_t w, logic [2:0] kind, logic [1:0] q);
    if (w.s.tc >= TC_W'(MAX_TOKENS)) return fail(w, ST_TOO_MANY);
    w = emit(w, EV_TOKEN, kind, q, 8'd0, 7'(w.s.tc), ST_OK);
    w.s.tc = w.s.tc + 1'b1;
    return w;
  endfunction

  function automatic work_t add_char(work_t w, logic [7:0] c);
    if (w.s.wlen == WL_W'(MAX_TOKEN_LEN)) return fail(w, ST_TOO_LONG);
    w = emit(w, EV_WORD_CHAR, KIND_WORD, w.s.cq, c, 7'(w.s.tc), ST_OK);
    w.s.wlen = w.s.wlen + 1'b1;
    return w;
  endfunction

  function automatic work_t unquoted_char(work_t w, logic [7:0] c);
    logic glob;
    glob = (c == CH_STAR) || (c == CH_QMARK) || (c == CH_LBRACK) || (c == CH_RBRACK);
    if (c == CH_SQUOTE || c == CH_DQUOTE) return fail(w, ST_SYNTAX);
    if (is_bad_single(c)) return fail(w, ST_UNSUP);
    // ? straight after $ is the only glob character let through
    if (glob && !(c == CH_QMARK && w.s.prev == CH_DOLLAR)) return fail(w, ST_UNSUP);
    return add_char(w, c);
  endfunction

  // Start of a new token
  function automatic work_t dispatch(work_t w, logic [7:0] c);
    if (is_space(c)) return w;
    if (c == CH_HASH) begin
      w.s.mode = M_COMMENT;
      return w;
    end
    if (c == CH_AMP) begin
      w.s.mode = M_AMP;
      return w;
    end
    if (c == CH_PIPE) begin
      w.s.pop = OP_PIPE;
      return w;
    end
    if (c == CH_LT) begin
      w.s.pop = OP_LT;
      return w;
    end
    if (c == CH_GT) begin
      w.s.pop = OP_GT;
      return w;
    end
    if (is_bad_single(c)) return fail(w, ST_UNSUP);
    w.s.wlen = '0;
    if (c == CH_SQUOTE) begin
      w.s.mode = M_SQ;
      w.s.cq   = Q_SINGLE;
      return w;
    end
    if (c == CH_DQUOTE) begin
      w.s.mode = M_DQ;
      w.s.cq   = Q_DOUBLE;
      return w;
    end
    w.s.mode = M_WORD;
    w.s.cq   = Q_NONE;
    return unquoted_char(w, c);
  endfunction

  function automatic work_t lex(work_t w, logic [7:0] c);
    logic [7:0] closer;
    closer = (w.s.mode == M_SQ) ? CH_SQUOTE : CH_DQUOTE;
    unique case (w.s.mode) inside
      M_BETWEEN: begin
        // Resolve an operator waiting for its lookahead byte
        unique case (w.s.pop)
          OP_PIPE: begin
            w.s.pop = OP_NONE;
            if (c == CH_PIPE) return push(w, KIND_OR, Q_NONE);
            w = push(w, KIND_PIPE, Q_NONE);
          end
          OP_LT: begin
            w.s.pop = OP_NONE;
            if (c == CH_LT) return fail(w, ST_UNSUP);
            w = push(w, KIND_IN, Q_NONE);
          end
          OP_GT: begin
            w.s.pop = OP_NONE;
            if (c == CH_GT) return push(w, KIND_APPEND, Q_NONE);
            w = push(w, KIND_OUT, Q_NONE);
          end
          default: ;
        endcase
        if (w.s.fe == ST_OK) w = dispatch(w, c);
      end
      M_WORD: begin
        if (is_space(c) || is_op(c)) begin
          w = push(w, KIND_WORD, Q_NONE);
          w.s.mode = M_BETWEEN;
          if (w.s.fe == ST_OK) w = dispatch(w, c);
        end else begin
          w = unquoted_char(w, c);
        end
      end
      M_SQ, M_DQ: begin
        if (c == closer) w.s.mode = M_CLOSED;
        else w = add_char(w, c);
      end
      M_CLOSED: begin
        if (!(is_space(c) || c == CH_HASH || is_op(c))) return fail(w, ST_SYNTAX);
        w = push(w, KIND_WORD, w.s.cq);
        w.s.mode = M_BETWEEN;
        w.s.cq   = Q_NONE;
        if (w.s.fe == ST_OK) w = dispatch(w, c);
      end
      M_AMP: begin
        w.s.mode = M_BETWEEN;
        if (c == CH_AMP) w = push(w, KIND_AND, Q_NONE);
        else w = fail(w, ST_UNSUP);
      end
      default: ;
    endcase
    return w;
  endfunction

  // Close whatever is open at end of line
  function automatic work_t flush(work_t w);
    if (w.s.fe != ST_OK) return w;
    unique case (w.s.mode) inside
      M_BETWEEN: begin
        unique case (w.s.pop)
          OP_PIPE: w = push(w, KIND_PIPE, Q_NONE);
          OP_LT:   w = push(w, KIND_IN, Q_NONE);
          OP_GT:   w = push(w, KIND_OUT, Q_NONE);
          default: ;
        endcase
      end
      M_WORD:     w = push(w, KIND_WORD, Q_NONE);
      M_SQ, M_DQ: w = fail(w, ST_SYNTAX);
      M_CLOSED:   w = push(w, KIND_WORD, w.s.cq);
      M_AMP:      w = fail(w, ST_UNSUP);
      default: ;
    endcase
    return w;
  endfunction

  // One byte through the lexer
  always_comb begin
    logic [2:0] stat;
    w_nxt   = '0;
    w_nxt.s = st_r;
    stat    = ST_OK;
    if (in_data.has_char && !w_nxt.s.nul) begin
      if (in_data.ch == CH_NUL) begin
        w_nxt.s.nul = 1'b1;
      end else begin
        // Saturating line length; overflow overrides any earlier error
        if (w_nxt.s.llen <= LL_W'(MAX_LINE_LEN)) w_nxt.s.llen = w_nxt.s.llen + 1'b1;
        if (w_nxt.s.llen > LL_W'(MAX_LINE_LEN)) w_nxt.s.fe = ST_TOO_LONG;
        if (w_nxt.s.fe == ST_OK && w_nxt.s.mode != M_COMMENT) w_nxt = lex(w_nxt, in_data.ch);
        w_nxt.s.prev = in_data.ch;
      end
    end
    if (in_data.end_of_line) begin
      w_nxt = flush(w_nxt);
      stat  = w_nxt.s.fe;
      if (stat == ST_OK && w_nxt.s.tc == '0) stat = ST_EMPTY;
      w_nxt = emit(w_nxt, EV_LINE, KIND_WORD, Q_NONE, 8'd0,
                   (stat == ST_OK) ? 7'(w_nxt.s.tc) : 7'd0, stat);
      w_nxt.s = RESET_ST;
    end
    if (w_nxt.n != '0) w_nxt.r[SLT_IDX_W'(w_nxt.n - 1'b1)].last = 1'b1;
  end

  assign bundle = '{res: w_nxt.r, cnt: w_nxt.n};

  // Lexer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= RESET_ST;
    end else if (in_fire) begin
      st_r <= w_nxt.s;
    end
  end

endmodule

>>> design/shell_line_tokenizer.sv
// Path: the first result of an input byte reaches out_ via the per-byte result buffer
// and then the output register; out_ready back-pressure can hold it in the buffer.
// Throughput: one byte per cycle while each byte yields at most one result and out_ready
// does not stall the output; a byte that yields several results (up to four) holds the
// input side until the single-result output port moves its last result out of the buffer.
// Reset: rst_n is synchronous, active low; it clears the lexer state and empties
// the result buffer and the output register.
module shell_line_tokenizer import slt_pkg::*; #(
  parameter int MAX_LINE_LEN  = SLT_MAX_LINE_LEN,
  parameter int MAX_TOKENS    = SLT_MAX_TOKENS,
  parameter int MAX_TOKEN_LEN = SLT_MAX_TOKEN_LEN
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  slt_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output slt_out_t out_data
);

  slt_bundle_t                    bundle;
  slt_out_t [SLT_MAX_RESULTS-1:0] pend_r;
  logic [SLT_CNT_W-1:0]           pend_cnt_r;
  logic [SLT_IDX_W-1:0]           pend_idx_r;
  slt_out_t                       out_r;
  logic                           out_valid_r;
  logic                           in_fire;
  logic                           out_move;

  slt_lexer #(
    .MAX_LINE_LEN  (MAX_LINE_LEN),
    .MAX_TOKENS    (MAX_TOKENS),
    .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
  ) u_lexer (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_data (in_data),
    .bundle  (bundle)
  );

  // Buffer to output register move, and input transfer when the buffer frees up
  assign out_move = (pend_cnt_r != '0) && (!out_valid_r || out_ready);
  assign in_ready = (pend_cnt_r == '0) || (pend_cnt_r == SLT_CNT_W'(1) && out_move);
  assign in_fire  = in_valid && in_ready;

  // Per-byte result buffer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_cnt_r <= '0;
      pend_idx_r <= '0;
    end else if (in_fire) begin
      pend_cnt_r <= bundle.cnt;
      pend_idx_r <= '0;
    end else if (out_move) begin
      pend_cnt_r <= pend_cnt_r - 1'b1;
      pend_idx_r <= pend_idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      pend_r <= bundle.res;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_move) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_move) begin
      out_r <= pend_r[pend_idx_r];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Buffer never holds more than one byte's results
  assert property (@(posedge clk) disable iff (!rst_n)
    pend_cnt_r <= SLT_CNT_W'(SLT_MAX_RESULTS))
    else $error("result buffer count out of range");

  // A new byte only lands once the previous results are gone or leaving
  assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> (pend_cnt_r == '0) || (pend_cnt_r == SLT_CNT_W'(1) && out_move))
    else $error("results overwritten before transfer");

  // Fresh results are read from slot zero
  assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && bundle.cnt != '0 |=> pend_idx_r == '0 && pend_cnt_r != '0)
    else $error("result buffer not loaded");

  // Line status is always the final result of its byte
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.event_res == EV_LINE |-> out_r.last)
    else $error("line status not marked last");

  // The last result of a byte leaves the buffer empty
  assert property (@(posedge clk) disable iff (!rst_n)
    out_move && pend_r[pend_idx_r].last && !in_fire |=> pend_cnt_r == '0)
    else $error("results left behind after last");

endmodule

>>> tb/sv/testbench.sv
module testbench;
  import slt_pkg::*;

  localparam int CYCLE_LIMIT   = 500000;
  localparam int RANDOM_ITEMS  = 105;
  localparam int DRAIN_CYCLES  = 8;
  localparam int PRINT_CAP     = 30;

  // Lexer modes and pending operator codes of the predictor
  typedef enum logic [2:0] {
    SM_BETWEEN, SM_WORD, SM_SQ, SM_DQ, SM_CLOSED, SM_COMMENT, SM_AMP
  } lex_mode_e;

  typedef enum logic [1:0] {PO_NONE, PO_PIPE, PO_IN, PO_OUT} pend_op_e;

  typedef struct {
    slt_in_t  item;
    bit       typed;
    slt_out_t want;
  } stim_row_t;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  slt_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  slt_out_t out_data;

  // Predictor state
  lex_mode_e   lx_mode;
  pend_op_e    lx_pend;
  logic [7:0]  lx_prev;
  int          lx_len;
  int          lx_tokens;
  int          lx_wlen;
  logic [1:0]  lx_quote;
  logic [2:0]  lx_err;
  bit          lx_nul;

  slt_out_t    step_results[$];
  slt_out_t    expected_events[$];
  stim_row_t   directed_rows[$];
  logic [7:0]  line_buf[$];

  int  mismatches;
  int  results_checked;
  int  stream_items;
  int  cycle_count;
  int  line_stats[6];
  bit  tx_burst;
  bit  rx_burst;

  string      word_chars = "abcdefghijklmnopqrstuvwxyzABCXYZ0123456789_-./=";
  string      odd_chars  = "$?#*[];(){}'\"";
  string      op_set[8]  = '{"&&", "||", "|", "<", ">", ">>", "&", "<<"};
  logic [7:0] blank_set[6] = '{CH_SPACE, CH_TAB, 8'h0A, 8'h0B, 8'h0C, CH_CR};

  shell_line_tokenizer DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #1 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_events.size());
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic void put_result(logic [1:0] ev, logic [2:0] kind, logic [1:0] q,
                                     logic [7:0] c, int idx, logic [2:0] st);
    slt_out_t r;
    if (step_results.size() >= SLT_MAX_RESULTS) return;
    r.event_res   = ev;
    r.token_kind  = kind;
    r.quote       = q;
    r.word_char   = c;
    r.token_index = 7'(idx);
    r.status      = st;
    r.last        = 1'b0;
    step_results.push_back(r);
  endfunction

  // only the first error of a line sticks (too long overrides elsewhere)
  function automatic void note_error(logic [2:0] st);
    if (lx_err == ST_OK) lx_err = st;
  endfunction

  function automatic void push_token(logic [2:0] kind, logic [1:0] q);
    if (lx_tokens >= SLT_MAX_TOKENS) begin
      note_error(ST_TOO_MANY);
      return;
    end
    put_result(EV_TOKEN, kind, q, CH_NUL, lx_tokens, ST_OK);
    lx_tokens++;
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic bit is_operator(logic [7:0] c);
    return c == CH_PIPE || c == CH_AMP || c == CH_LT || c == CH_GT;
  endfunction

  function automatic bit is_forbidden(logic [7:0] c);
    return c == CH_SEMI || c == CH_LPAREN || c == CH_RPAREN ||
           c == CH_LBRACE || c == CH_RBRACE;
  endfunction

  function automatic void add_word_char(logic [7:0] c);
    if (lx_wlen + 1 > SLT_MAX_TOKEN_LEN) begin
      note_error(ST_TOO_LONG);
      return;
    end
    put_result(EV_WORD_CHAR, KIND_WORD, lx_quote, c, lx_tokens, ST_OK);
    lx_wlen++;
  endfunction

  // Unquoted word byte: quotes, separators and globs are rejected ($? is allowed)
  function automatic void plain_char(logic [7:0] c);
    if (c == CH_SQUOTE || c == CH_DQUOTE) begin
      note_error(ST_SYNTAX);
      return;
    end
    if (is_forbidden(c)) begin
      note_error(ST_UNSUP);
      return;
    end
    if ((c == CH_STAR || c == CH_QMARK || c == CH_LBRACK || c == CH_RBRACK) &&
        !(c == CH_QMARK && lx_prev == CH_DOLLAR)) begin
      note_error(ST_UNSUP);
      return;
    end
    add_word_char(c);
  endfunction

  // First byte of a new token
  function automatic void start_token(logic [7:0] c);
    if (is_blank(c)) return;
    if (c == CH_HASH) begin
      lx_mode = SM_COMMENT;
      return;
    end
    if (c == CH_AMP) begin
      lx_mode = SM_AMP;
      return;
    end
    if (c == CH_PIPE) begin
      lx_pend = PO_PIPE;
      return;
    end
    if (c == CH_LT) begin
      lx_pend = PO_IN;
      return;
    end
    if (c == CH_GT) begin
      lx_pend = PO_OUT;
      return;
    end
    if (is_forbidden(c)) begin
      note_error(ST_UNSUP);
      return;
    end
    lx_wlen = 0;
    if (c == CH_SQUOTE) begin
      lx_mode  = SM_SQ;
      lx_quote = Q_SINGLE;
      return;
    end
    if (c == CH_DQUOTE) begin
      lx_mode  = SM_DQ;
      lx_quote = Q_DOUBLE;
      return;
    end
    lx_mode  = SM_WORD;
    lx_quote = Q_NONE;
    plain_char(c);
  endfunction

  function automatic void lex_byte(logic [7:0] c);
    case (lx_mode)
      SM_BETWEEN: begin
        // resolve a held operator with one byte of lookahead
        case (lx_pend)
          PO_PIPE: begin
            lx_pend = PO_NONE;
            if (c == CH_PIPE) begin
              push_token(KIND_OR, Q_NONE);
              return;
            end
            push_token(KIND_PIPE, Q_NONE);
          end
          PO_IN: begin
            lx_pend = PO_NONE;
            if (c == CH_LT) begin
              note_error(ST_UNSUP);
              return;
            end
            push_token(KIND_IN, Q_NONE);
          end
          PO_OUT: begin
            lx_pend = PO_NONE;
            if (c == CH_GT) begin
              push_token(KIND_APPEND, Q_NONE);
              return;
            end
            push_token(KIND_OUT, Q_NONE);
          end
          default: ;
        endcase
        if (lx_err == ST_OK) start_token(c);
      end
      SM_WORD: begin
        if (is_blank(c) || is_operator(c)) begin
          push_token(KIND_WORD, Q_NONE);
          lx_mode = SM_BETWEEN;
          if (lx_err == ST_OK) start_token(c);
        end else begin
          plain_char(c);
        end
      end
      SM_SQ, SM_DQ: begin
        if (c == ((lx_mode == SM_SQ) ? CH_SQUOTE : CH_DQUOTE)) lx_mode = SM_CLOSED;
        else add_word_char(c);
      end
      SM_CLOSED: begin
        if (!(is_blank(c) || c == CH_HASH || is_operator(c))) begin
          note_error(ST_SYNTAX);
        end else begin
          push_token(KIND_WORD, lx_quote);
          lx_mode  = SM_BETWEEN;
          lx_quote = Q_NONE;
          if (lx_err == ST_OK) start_token(c);
        end
      end
      SM_AMP: begin
        lx_mode = SM_BETWEEN;
        if (c == CH_AMP) push_token(KIND_AND, Q_NONE);
        else note_error(ST_UNSUP);
      end
      default: ;
    endcase
  endfunction

  // End of line: finish whatever token is open
  function automatic void close_line();
    if (lx_err != ST_OK) return;
    case (lx_mode)
      SM_BETWEEN: begin
        case (lx_pend)
          PO_PIPE: push_token(KIND_PIPE, Q_NONE);
          PO_IN:   push_token(KIND_IN, Q_NONE);
          PO_OUT:  push_token(KIND_OUT, Q_NONE);
          default: ;
        endcase
      end
      SM_WORD:      push_token(KIND_WORD, Q_NONE);
      SM_SQ, SM_DQ: note_error(ST_SYNTAX);
      SM_CLOSED:    push_token(KIND_WORD, lx_quote);
      SM_AMP:       note_error(ST_UNSUP);
      default: ;
    endcase
  endfunction

  function automatic void clear_lexer();
    lx_mode   = SM_BETWEEN;
    lx_pend   = PO_NONE;
    lx_prev   = CH_NUL;
    lx_len    = 0;
    lx_tokens = 0;
    lx_wlen   = 0;
    lx_quote  = Q_NONE;
    lx_err    = ST_OK;
    lx_nul    = 1'b0;
  endfunction

  // Works out the results of one transfer; queues them when record is set
  function automatic void predict_item(slt_in_t it, bit record);
    logic [2:0] st;
    step_results.delete();
    if (it.has_char && !lx_nul) begin
      if (it.ch == CH_NUL) begin
        lx_nul = 1'b1;
      end else begin
        if (lx_len <= SLT_MAX_LINE_LEN) lx_len++;
        if (lx_len > SLT_MAX_LINE_LEN) lx_err = ST_TOO_LONG;
        if (lx_err == ST_OK && lx_mode != SM_COMMENT) lex_byte(it.ch);
        lx_prev = it.ch;
      end
    end
    if (it.end_of_line) begin
      close_line();
      st = lx_err;
      if (st == ST_OK && lx_tokens == 0) st = ST_EMPTY;
      put_result(EV_LINE, KIND_WORD, Q_NONE, CH_NUL, (st == ST_OK) ? lx_tokens : 0, st);
      clear_lexer();
    end
    if (step_results.size() > 0) step_results[step_results.size()-1].last = 1'b1;
    if (record) foreach (step_results[i]) expected_events.push_back(step_results[i]);
  endfunction

  // ----------------------------------------------------------------- checking

  task automatic report_mismatch(string what);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("MISMATCH at result %0d (cycle %0d): %s", results_checked, cycle_count, what);
  endtask

  task automatic diff_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  task automatic check_result(slt_out_t got);
    slt_out_t want;
    if (expected_events.size() == 0) begin
      report_mismatch($sformatf("unexpected result %h", got));
      return;
    end
    want = expected_events.pop_front();
    diff_field("event_res", got.event_res, want.event_res);
    diff_field("token_kind", got.token_kind, want.token_kind);
    diff_field("quote", got.quote, want.quote);
    diff_field("word_char", got.word_char, want.word_char);
    diff_field("token_index", got.token_index, want.token_index);
    diff_field("status", got.status, want.status);
    diff_field("last", got.last, want.last);
    if (got.event_res == EV_LINE && got.status < 6) line_stats[got.status]++;
    results_checked++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_result(out_data);
  end

  // Result side back-pressure: random stall before each transfer, bursts without
  initial begin
    int gap;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if ($urandom_range(0, 15) == 0) rx_burst = !rx_burst;
      gap = rx_burst ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // ----------------------------------------------------------------- stimulus

  // Presents one item and returns at the edge where it is transferred
  task automatic send_item(slt_in_t item);
    int gap;
    if ($urandom_range(0, 15) == 0) tx_burst = !tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic apply_item(logic has, logic [7:0] ch, logic eol);
    slt_in_t it;
    it.has_char    = has;
    it.ch          = ch;
    it.end_of_line = eol;
    send_item(it);
    predict_item(it, 1'b1);
    if (has || eol) stream_items++;
  endtask

  function automatic void add_row(logic has, logic [7:0] ch, logic eol,
                                  bit typed = 1'b0, logic [2:0] st = ST_OK);
    stim_row_t r;
    r.item.has_char      = has;
    r.item.ch            = ch;
    r.item.end_of_line   = eol;
    r.typed              = typed;
    r.want.event_res     = EV_LINE;
    r.want.token_kind    = KIND_WORD;
    r.want.quote         = Q_NONE;
    r.want.word_char     = CH_NUL;
    r.want.token_index   = 7'd0;
    r.want.status        = st;
    r.want.last          = 1'b1;
    directed_rows.push_back(r);
  endfunction

  function automatic void add_text(string s, bit eol_at_end);
    for (int i = 0; i < s.len(); i++)
      add_row(1'b1, s[i], eol_at_end && (i == s.len() - 1));
  endfunction

  function automatic void add_blanks();
    repeat ($urandom_range(1, 2)) line_buf.push_back(blank_set[$urandom_range(0, 5)]);
  endfunction

  function automatic void add_word();
    int pick;
    repeat ($urandom_range(1, 5)) begin
      pick = $urandom_range(0, 19);
      if (pick < 15) begin
        line_buf.push_back(word_chars[$urandom_range(0, word_chars.len() - 1)]);
      end else if (pick < 17) begin
        line_buf.push_back(odd_chars[$urandom_range(0, odd_chars.len() - 1)]);
      end else if (pick == 17) begin
        line_buf.push_back(CH_DOLLAR);
        line_buf.push_back(CH_QMARK);
      end else begin
        line_buf.push_back(8'($urandom_range(1, 255)));
      end
    end
  endfunction

  // Quoted word with random content (never NUL or its own quote); left open now and then
  function automatic void add_quoted(logic [7:0] q);
    logic [7:0] c;
    line_buf.push_back(q);
    repeat ($urandom_range(0, 5)) begin
      c = 8'($urandom_range(1, 255));
      line_buf.push_back((c == q) ? 8'h61 : c);
    end
    if ($urandom_range(0, 6) != 0) line_buf.push_back(q);
  endfunction

  function automatic void add_operator();
    string op;
    op = ($urandom_range(0, 7) == 0) ? op_set[$urandom_range(6, 7)]
                                     : op_set[$urandom_range(0, 5)];
    for (int i = 0; i < op.len(); i++) line_buf.push_back(op[i]);
  endfunction

  // Mostly well-formed command lines, the rest raw byte noise
  function automatic void gen_line();
    line_buf.delete();
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 10))
        line_buf.push_back(($urandom_range(0, 9) == 0) ? CH_NUL : 8'($urandom_range(1, 255)));
      return;
    end
    repeat ($urandom_range(1, 5)) begin
      if (line_buf.size() > 0 ? ($urandom_range(0, 9) < 7) : ($urandom_range(0, 3) == 0))
        add_blanks();
      case ($urandom_range(0, 5))
        0, 1:    add_word();
        2:       add_quoted(CH_SQUOTE);
        3:       add_quoted(CH_DQUOTE);
        default: add_operator();
      endcase
    end
    if ($urandom_range(0, 4) == 0) begin
      if ($urandom_range(0, 1) == 0) add_blanks();
      line_buf.push_back(CH_HASH);
      repeat ($urandom_range(0, 4)) line_buf.push_back(8'($urandom_range(1, 255)));
    end
  endfunction

  // Sends line_buf; the end of line rides on the last byte or on an empty item
  task automatic send_line(bit separate_eol);
    for (int i = 0; i < line_buf.size(); i++) begin
      if ($urandom_range(0, 11) == 0) apply_item(1'b0, 8'($urandom_range(0, 255)), 1'b0);
      apply_item(1'b1, line_buf[i], !separate_eol && (i == line_buf.size() - 1));
    end
    if (separate_eol || line_buf.size() == 0)
      apply_item(1'b0, 8'($urandom_range(0, 255)), 1'b1);
  endtask

  // --------------------------------------------------------------------- main

  initial begin
    int directed_items;
    int random_start;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cycle_count = 0;
    mismatches  = 0;
    tx_burst    = 1'b0;
    rx_burst    = 1'b0;
    clear_lexer();

    // Directed table: empty lines, every operator, quoting, NUL and 0xFF bytes
    add_row(1'b0, CH_NUL, 1'b1, 1'b1, ST_EMPTY);
    add_row(1'b0, 8'hFF, 1'b0);
    add_text("x&&y||'q'>>\"z\"|<>#", 1'b1);
    add_row(1'b1, CH_AMP, 1'b1, 1'b1, ST_UNSUP);
    add_text("<", 1'b0);
    add_row(1'b1, CH_LT, 1'b1, 1'b1, ST_UNSUP);
    add_row(1'b1, 8'hFF, 1'b0);
    add_row(1'b1, CH_NUL, 1'b1);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].item);
      if (directed_rows[i].typed) begin
        predict_item(directed_rows[i].item, 1'b0);
        expected_events.push_back(directed_rows[i].want);
      end else begin
        predict_item(directed_rows[i].item, 1'b1);
      end
      if (directed_rows[i].item.has_char || directed_rows[i].item.end_of_line)
        stream_items++;
    end
    directed_items = stream_items;

    // Random command lines
    random_start = stream_items;
    while (stream_items - random_start < RANDOM_ITEMS) begin
      gen_line();
      send_line($urandom_range(0, 7) == 0);
    end

    in_valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d items (%0d directed) and %0d checked results", stream_items,
             directed_items, results_checked);
    $display("Lines: ok %0d, empty %0d, too long %0d, too many %0d, unsupported %0d, syntax %0d",
             line_stats[0], line_stats[1], line_stats[2], line_stats[3], line_stats[4],
             line_stats[5]);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
